### hdl/assert_macros.svh
// Assertion macros used by the checker file of the interpolator.
// Needs nothing else; every macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### hdl/pli_pkg.sv
// Package of the piecewise linear interpolator: field widths, codes and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package pli_pkg;

	localparam int IDX_W          = 6;
	localparam int TIME_W         = 32;
	localparam int VAL_W          = 48;
	localparam int PC_W           = 7;
	localparam int MAX_POINTS_DEF = 64;
	localparam int DIV_STEPS      = 48;
	localparam int DIV_CNT_W      = 6;

	localparam logic [PC_W-1:0] PC_RESET = 7'd2;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic             load;
		logic             rd_en;
		logic             latch_q;
		logic             shift_prev;
		logic             clamp_lo;
		logic             clamp_hi;
		logic             setup;
		logic             mul_lo;
		logic             mul_hi;
		logic             add;
		logic             div_step;
		logic             finish;
		logic             load_out;
		logic [IDX_W-1:0] seg;
	} cmd_t;

	typedef struct packed {
		logic q_le_t;
	} sts_t;

endpackage

`default_nettype wire

### hdl/pli_if.sv
// Channel interfaces of the interpolator: request beats in, result beats out.
// Depends on pli_pkg for the field widths.
`default_nettype none

interface pli_in_if;
	import pli_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     op;
	logic [IDX_W-1:0]         entry_index;
	logic signed [TIME_W-1:0] entry_time;
	logic signed [VAL_W-1:0]  entry_value;
	logic signed [TIME_W-1:0] query_time;

	modport source (
		output valid, op, entry_index, entry_time, entry_value, query_time,
		input  ready
	);
	modport sink (
		input  valid, op, entry_index, entry_time, entry_value, query_time,
		output ready
	);
endinterface

interface pli_out_if;
	import pli_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] result_value;
	logic [IDX_W-1:0]        segment;
	logic                    below_first;
	logic                    above_last;

	modport source (
		output valid, result_value, segment, below_first, above_last,
		input  ready
	);
	modport sink (
		input  valid, result_value, segment, below_first, above_last,
		output ready
	);
endinterface

`default_nettype wire

### hdl/pli_dp.sv
// Interpolator datapath: breakpoint memories, segment registers, shared
// 32x32 multiplier, restoring divider and result registers. Uses pli_pkg.
`default_nettype none

module pli_dp #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  wire logic                              clk,
	input  wire logic [pli_pkg::IDX_W-1:0]         entry_index,
	input  wire logic signed [pli_pkg::TIME_W-1:0] entry_time,
	input  wire logic signed [pli_pkg::VAL_W-1:0]  entry_value,
	input  wire logic signed [pli_pkg::TIME_W-1:0] query_time,
	input  wire logic [AW-1:0]                     rd_addr,
	input  wire pli_pkg::cmd_t                     cmd,
	output pli_pkg::sts_t                          sts,
	output logic signed [pli_pkg::VAL_W-1:0]       result_value,
	output logic [pli_pkg::IDX_W-1:0]              segment,
	output logic                                   below_first,
	output logic                                   above_last
);
	import pli_pkg::*;

	logic signed [TIME_W-1:0] time_mem [MAX_POINTS];
	logic signed [VAL_W-1:0]  value_mem [MAX_POINTS];

	logic signed [TIME_W-1:0] rd_time_q, q_q, t0_q;
	logic signed [VAL_W-1:0]  rd_val_q, y0_q, res_q;
	logic [31:0]              dt_q, dd_q, rem_q;
	logic [VAL_W-1:0]         mag_q, sh_q;
	logic                     neg_q, lo_q, hi_q;
	logic [63:0]              prod_q, acc_q;
	logic [IDX_W-1:0]         seg_q;

	logic [AW-1:0]  wr_addr;
	logic           idx_ok;
	logic [VAL_W:0] dy;
	logic [31:0]    mul_a;
	logic [63:0]    mul_p;
	logic [47:0]    hi_sum;
	logic [32:0]    div_cat;
	logic           div_ge;

	assign wr_addr = AW'(entry_index);
	assign idx_ok  = 32'(entry_index) < MAX_POINTS;

	always_ff @(posedge clk) begin
		if (cmd.load && idx_ok) begin
			time_mem[wr_addr]  <= entry_time;
			value_mem[wr_addr] <= entry_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_time_q <= time_mem[rd_addr];
			rd_val_q  <= value_mem[rd_addr];
		end
	end

	assign sts.q_le_t = q_q <= rd_time_q;

	assign dy      = {rd_val_q[VAL_W-1], rd_val_q} - {y0_q[VAL_W-1], y0_q};
	assign mul_a   = cmd.mul_hi ? {16'b0, mag_q[47:32]} : mag_q[31:0];
	assign mul_p   = mul_a * dt_q;
	assign hi_sum  = prod_q[47:0] + {16'b0, acc_q[63:32]};
	assign div_cat = {rem_q, sh_q[VAL_W-1]};
	assign div_ge  = div_cat >= {1'b0, dd_q};

	always_ff @(posedge clk) begin
		if (cmd.latch_q)
			q_q <= query_time;
		if (cmd.shift_prev) begin
			t0_q <= rd_time_q;
			y0_q <= rd_val_q;
		end
		if (cmd.setup) begin
			dt_q  <= 32'(q_q - t0_q);
			dd_q  <= 32'(rd_time_q - t0_q);
			neg_q <= dy[VAL_W];
			mag_q <= dy[VAL_W] ? VAL_W'(-dy) : dy[VAL_W-1:0];
		end
		if (cmd.mul_lo)
			prod_q <= mul_p;
		if (cmd.mul_hi) begin
			prod_q <= mul_p;
			acc_q  <= prod_q;
		end
		if (cmd.add) begin
			rem_q <= hi_sum[47:16];
			sh_q  <= {hi_sum[15:0], acc_q[31:0]};
		end
		if (cmd.div_step) begin
			rem_q <= div_ge ? 32'(div_cat - {1'b0, dd_q}) : div_cat[31:0];
			sh_q  <= {sh_q[VAL_W-2:0], div_ge};
		end
		if (cmd.clamp_lo || cmd.clamp_hi) begin
			res_q <= rd_val_q;
			seg_q <= cmd.seg;
			lo_q  <= cmd.clamp_lo;
			hi_q  <= cmd.clamp_hi;
		end
		if (cmd.finish) begin
			res_q <= neg_q ? y0_q - sh_q : y0_q + sh_q;
			seg_q <= cmd.seg;
			lo_q  <= 1'b0;
			hi_q  <= 1'b0;
		end
		if (cmd.load_out) begin
			result_value <= res_q;
			segment      <= seg_q;
			below_first  <= lo_q;
			above_last   <= hi_q;
		end
	end

endmodule

`default_nettype wire

### hdl/pli_ctrl.sv
// Interpolator controller: point count register, one-hot sequencer for
// search, multiply and divide, and the output valid flag. Uses pli_pkg.
`default_nettype none

module pli_ctrl #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF,
	localparam int AW = $clog2(MAX_POINTS)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [pli_pkg::PC_W-1:0]   cfg_wdata,
	input  wire logic                       in_valid,
	input  wire logic                       in_op,
	output logic                            in_ready,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [AW-1:0]                   rd_addr,
	output pli_pkg::cmd_t                   cmd,
	input  wire pli_pkg::sts_t              sts
);
	import pli_pkg::*;

	localparam int NW = AW + 1;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_FIRST  = 9'b000000010,
		S_SCAN   = 9'b000000100,
		S_MUL_LO = 9'b000001000,
		S_MUL_HI = 9'b000010000,
		S_ADD    = 9'b000100000,
		S_DIV    = 9'b001000000,
		S_FINISH = 9'b010000000,
		S_DONE   = 9'b100000000
	} state_t;

	state_t               state_q, state_d;
	logic [PC_W-1:0]      pc_q;
	logic [AW-1:0]        idx_q, last_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;
	logic [NW-1:0]        n_eff;

	// clamp point count to [2, MAX_POINTS]
	always_comb begin
		if (pc_q < PC_W'(2))
			n_eff = NW'(2);
		else if (32'(pc_q) > MAX_POINTS)
			n_eff = NW'(MAX_POINTS);
		else
			n_eff = NW'(pc_q);
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		cmd.seg = IDX_W'(idx_q);
		rd_addr = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_op == OP_QUERY) begin
						cmd.rd_en   = 1'b1;
						cmd.latch_q = 1'b1;
						state_d     = S_FIRST;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			S_FIRST: begin
				if (sts.q_le_t) begin
					cmd.clamp_lo = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.shift_prev = 1'b1;
					cmd.rd_en      = 1'b1;
					rd_addr        = AW'(1);
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.q_le_t) begin
					cmd.setup = 1'b1;
					state_d   = S_MUL_LO;
				end else if (idx_q == last_q) begin
					cmd.clamp_hi = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.shift_prev = 1'b1;
					cmd.rd_en      = 1'b1;
					rd_addr        = idx_q + AW'(1);
				end
			end
			S_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = S_MUL_HI;
			end
			S_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = S_ADD;
			end
			S_ADD: begin
				cmd.add = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST)
					state_d = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pc_q        <= PC_RESET;
			idx_q       <= '0;
			last_q      <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				pc_q <= cfg_wdata;
			if (state_q == S_IDLE)
				idx_q <= '0;
			else if (cmd.shift_prev)
				idx_q <= rd_addr;
			if (cmd.latch_q)
				last_q <= AW'(n_eff - NW'(1));
			if (cmd.add)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

### hdl/piecewise_linear_interpolator.sv
// Piecewise linear interpolator. The request channel carries load beats
// (op 0: write one breakpoint at entry_index; indexes at or above MAX_POINTS
// are dropped) and query beats (op 1). Each query gives one result beat;
// loads give none. cfg_we/cfg_wdata set point_count (reset 2, clamped to
// 2..MAX_POINTS when used); write it only while the block is idle.
// A query clamps low after reading the first breakpoint, clamps high after
// scanning up to the last active breakpoint, and otherwise interpolates:
// one memory read per scanned breakpoint, then two multiplier passes, one
// add and a 48-step restoring divide. A load leaves the request side ready.
// One query is in flight at a time; the request side is ready only between
// items. The result sits in an output register, so a stalled receiver
// blocks the next result only, not the next acceptance. Reset clears the
// sequencer and the output valid and sets point_count to 2; table contents
// are undefined until loaded. Depends on pli_pkg, pli_if, pli_ctrl, pli_dp.
`default_nettype none

module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [pli_pkg::PC_W-1:0] cfg_wdata,
	pli_in_if.sink                        in_ch,
	pli_out_if.source                     out_ch
);
	import pli_pkg::*;

	localparam int AW = $clog2(MAX_POINTS);

	cmd_t          cmd;
	sts_t          sts;
	logic [AW-1:0] rd_addr;

	pli_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.rd_addr   (rd_addr),
		.cmd       (cmd),
		.sts       (sts)
	);

	pli_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk          (clk),
		.entry_index  (in_ch.entry_index),
		.entry_time   (in_ch.entry_time),
		.entry_value  (in_ch.entry_value),
		.query_time   (in_ch.query_time),
		.rd_addr      (rd_addr),
		.cmd          (cmd),
		.sts          (sts),
		.result_value (out_ch.result_value),
		.segment      (out_ch.segment),
		.below_first  (out_ch.below_first),
		.above_last   (out_ch.above_last)
	);

endmodule

`default_nettype wire

### hdl/pli_checker.sv
// Port-level checks for the interpolator, bound to the top level.
// Depends on assert_macros.svh and pli_pkg.
`default_nettype none
`include "assert_macros.svh"

module pli_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_op,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [pli_pkg::IDX_W-1:0]   segment,
	input wire logic                        below_first,
	input wire logic                        above_last
);
	import pli_pkg::*;

	// result beat stays offered until taken
	`PLI_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// a result clamps at most one way
	`PLI_ASSERT_IMP(a_one_clamp, clk, arst_n, out_valid, !(below_first && above_last))
	// low clamp reports the first breakpoint
	`PLI_ASSERT_IMP(a_low_seg, clk, arst_n, out_valid && below_first, segment == '0)
	// a query beat closes the request side for the search
	`PLI_ASSERT_NXT(a_query_busy, clk, arst_n, in_valid && in_ready && (in_op == OP_QUERY),
		!in_ready)

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.in_op       (in_ch.op),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.segment     (out_ch.segment),
	.below_first (out_ch.below_first),
	.above_last  (out_ch.above_last)
);

`default_nettype wire

### tb/tb_piecewise_linear_interpolator.sv
`timescale 1ns / 1ps
// Testbench of the piecewise linear interpolator: loads breakpoint tables, sends queries
// and checks every result beat against an interpolation model kept in this module.
// Depends on pli_pkg, pli_if (pli_in_if, pli_out_if) and piecewise_linear_interpolator.

module tb_piecewise_linear_interpolator;
	import pli_pkg::*;

	localparam int TABLE_DEPTH    = MAX_POINTS_DEF;
	localparam int RESET_CYCLES   = 8;
	localparam int TARGET_ITEMS   = 800;
	localparam int STALL_PCT      = 18;
	localparam int SETTLE_CYCLES  = 8;
	localparam int END_CYCLES     = 130;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	localparam logic signed [TIME_W-1:0] TIME_MIN = 32'sh8000_0000;
	localparam logic signed [TIME_W-1:0] TIME_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0]  VAL_MIN  = 48'sh8000_0000_0000;
	localparam logic signed [VAL_W-1:0]  VAL_MAX  = 48'sh7FFF_FFFF_FFFF;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0]        segment;
		logic                    below;
		logic                    above;
	} interp_result_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [PC_W-1:0]  cfg_wdata;

	pli_in_if  in_ch ();
	pli_out_if out_ch ();

	piecewise_linear_interpolator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// breakpoint table and count as the block should hold them
	logic signed [TIME_W-1:0] bp_time  [TABLE_DEPTH];
	logic signed [VAL_W-1:0]  bp_value [TABLE_DEPTH];
	logic [PC_W-1:0]          point_count;
	interp_result_t           expected_results [$];
	interp_result_t           expected_head;

	bit calm;
	int failures;
	int results_checked;
	int loads_sent;
	int queries_sent;
	int clamps_low;
	int clamps_high;
	int settings_used;
	int watchdog_quiet;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	function automatic int active_points();
		if (point_count < 2)
			return 2;
		if (point_count > TABLE_DEPTH)
			return TABLE_DEPTH;
		return int'(point_count);
	endfunction

	function automatic interp_result_t interp_predict(input logic signed [TIME_W-1:0] q);
		interp_result_t r;
		int n;
		longint t0, dt, dd, y0, dy, mag, frac;
		logic [95:0] num;
		n = active_points();
		r.below = 1'b0;
		r.above = 1'b0;
		if (q <= bp_time[0]) begin
			r.value   = bp_value[0];
			r.segment = '0;
			r.below   = 1'b1;
			return r;
		end
		r.value   = bp_value[n-1];
		r.segment = IDX_W'(n - 1);
		r.above   = 1'b1;
		for (int i = 1; i < n; i++) begin
			if (q <= bp_time[i]) begin
				t0   = bp_time[i-1];
				y0   = bp_value[i-1];
				dt   = longint'(q) - t0;
				dd   = longint'(bp_time[i]) - t0;
				dy   = longint'(bp_value[i]) - y0;
				mag  = (dy < 0) ? -dy : dy;
				num  = 96'(mag) * 96'(dt) / 96'(dd);
				frac = longint'(num[63:0]);
				r.value   = (dy < 0) ? VAL_W'(y0 - frac) : VAL_W'(y0 + frac);
				r.segment = IDX_W'(i);
				r.above   = 1'b0;
				return r;
			end
		end
		return r;
	endfunction

	function automatic logic signed [VAL_W-1:0] rand_value();
		return VAL_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic signed [TIME_W-1:0] sat_time(input longint t);
		if (t < -64'sd2147483648)
			return TIME_MIN;
		if (t > 64'sd2147483647)
			return TIME_MAX;
		return TIME_W'(t);
	endfunction

	// entered and left at a falling edge; valid stays high on return
	task automatic send_beat(input logic kind, input logic [IDX_W-1:0] idx,
			input logic signed [TIME_W-1:0] et, input logic signed [VAL_W-1:0] ev,
			input logic signed [TIME_W-1:0] qt);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.op          = kind;
		in_ch.entry_index = idx;
		in_ch.entry_time  = et;
		in_ch.entry_value = ev;
		in_ch.query_time  = qt;
		in_ch.valid       = 1'b1;
		do
			@(posedge clk);
		while (!in_ch.ready);
		if (kind == OP_LOAD) begin
			bp_time[idx]  = et;
			bp_value[idx] = ev;
			loads_sent++;
		end else begin
			expected_results.push_back(interp_predict(qt));
			if (expected_results[$].below)
				clamps_low++;
			if (expected_results[$].above)
				clamps_high++;
			queries_sent++;
		end
		@(negedge clk);
	endtask

	task automatic load_point(input int idx, input logic signed [TIME_W-1:0] t,
			input logic signed [VAL_W-1:0] v);
		send_beat(OP_LOAD, IDX_W'(idx), t, v, TIME_W'($urandom()));
	endtask

	task automatic query_at(input logic signed [TIME_W-1:0] q);
		send_beat(OP_QUERY, IDX_W'($urandom()), TIME_W'($urandom()), rand_value(), q);
	endtask

	task automatic drain_results();
		in_ch.valid = 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_point_count(input logic [PC_W-1:0] count);
		drain_results();
		cfg_wdata = count;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we      = 1'b0;
		point_count = count;
		settings_used++;
	endtask

	// reset count of two: full-range endpoints, then a falling segment
	task automatic test_two_points();
		load_point(0, TIME_MIN, VAL_MIN);
		load_point(1, TIME_MAX, VAL_MAX);
		query_at(TIME_MIN);
		query_at(TIME_MIN + 1);
		query_at(32'sd0);
		query_at(32'sh4000_0000);
		query_at(TIME_MAX);
		load_point(0, 32'sh0001_0000, 48'sh0000_0005_0000);
		load_point(1, 32'sh0003_0000, -48'sh0000_0001_0000);
		query_at(32'sd0);
		query_at(32'sh0002_0000);
		query_at(32'sh0001_0001);
		query_at(32'sh0003_0000);
		query_at(32'sh0004_0000);
		query_at(TIME_MIN);
		query_at(TIME_MAX);
	endtask

	// out-of-order times with a repeated first time
	task automatic test_unsorted_table();
		set_point_count(PC_W'(4));
		load_point(0, 32'sh000A_0000, 48'sh0000_0064_0000);
		load_point(1, 32'sh000A_0000, -48'sh0000_0007_0000);
		load_point(2, 32'sh0005_0000, 48'sh0000_0003_0000);
		load_point(3, 32'sh0014_0000, -48'sh0000_0032_0000);
		query_at(32'sh000A_0000);
		query_at(32'sh0007_0000);
		query_at(32'sh000C_0000);
		query_at(32'sh0014_0000);
		query_at(32'sh0019_0000);
	endtask

	task automatic test_random_tables();
		int start_items, phase, n, kind, nq;
		logic [PC_W-1:0] count;
		longint stride_max, room, stride, t, lo, hi;
		logic signed [VAL_W-1:0] v;
		logic signed [TIME_W-1:0] q;
		start_items = loads_sent + queries_sent;
		phase = 0;
		while (loads_sent + queries_sent - start_items < TARGET_ITEMS) begin
			case ($urandom_range(9))
				0: begin
					case ($urandom_range(5))
						0: count = PC_W'(0);
						1: count = PC_W'(1);
						2: count = PC_W'(2);
						3: count = PC_W'(64);
						4: count = PC_W'(65);
						default: count = PC_W'(127);
					endcase
				end
				8, 9: count = PC_W'($urandom_range(9, 64));
				default: count = PC_W'($urandom_range(2, 8));
			endcase
			if (phase == 0)
				count = PC_W'(64);
			set_point_count(count);
			calm = (phase >= 6 && phase < 10);
			n = active_points();
			kind = $urandom_range(3);
			case (kind)
				0: stride_max = 64;
				1: stride_max = 65536;
				default: stride_max = 64'hFFFF_FFFF / (n - 1);
			endcase
			room = 64'hFFFF_FFFF - stride_max * (n - 1);
			t = -64'sd2147483648 + longint'({$urandom(), $urandom()} % (room + 1));
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(1))
					v = rand_value();
				else
					v = VAL_W'(longint'($urandom_range(0, 2097152)) - 1048576);
				if (kind == 3) begin
					load_point(i, TIME_W'($urandom()), v);
				end else begin
					load_point(i, TIME_W'(t), v);
					if (kind == 1 && $urandom_range(3) == 0)
						stride = 0;
					else
						stride = longint'($urandom_range(1, 32'(stride_max)));
					t = t + stride;
				end
			end
			nq = $urandom_range(8, 24);
			repeat (nq) begin
				if ($urandom_range(9) == 0)
					load_point($urandom_range(TABLE_DEPTH - 1), TIME_W'($urandom()),
						rand_value());
				lo = (bp_time[0] < bp_time[n-1]) ? bp_time[0] : bp_time[n-1];
				hi = (bp_time[0] < bp_time[n-1]) ? bp_time[n-1] : bp_time[0];
				case ($urandom_range(15))
					0: q = bp_time[0];
					1: q = bp_time[$urandom_range(n - 1)];
					2: q = sat_time(longint'(bp_time[0]) - $urandom_range(1, 1000));
					3: q = sat_time(longint'(bp_time[n-1]) + $urandom_range(1, 1000));
					4: q = $urandom_range(1) ? TIME_MIN : TIME_MAX;
					5: q = TIME_W'($urandom());
					default: q = TIME_W'(lo + longint'({$urandom(), $urandom()} % (hi - lo + 1)));
				endcase
				query_at(q);
			end
			phase++;
		end
		calm = 1'b0;
	endtask

	always @(negedge clk)
		out_ch.ready <= calm || ($urandom_range(99) >= STALL_PCT);

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result beat: value %0d segment %0d lo %0b hi %0b",
						out_ch.result_value, out_ch.segment, out_ch.below_first,
						out_ch.above_last);
			end else begin
				expected_head = expected_results.pop_front();
				results_checked++;
				if (out_ch.result_value !== expected_head.value
						|| out_ch.segment !== expected_head.segment
						|| out_ch.below_first !== expected_head.below
						|| out_ch.above_last !== expected_head.above) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("result %0d: exp value %0d seg %0d lo %0b hi %0b, got value %0d seg %0d lo %0b hi %0b",
							results_checked, expected_head.value, expected_head.segment,
							expected_head.below, expected_head.above, out_ch.result_value,
							out_ch.segment, out_ch.below_first, out_ch.above_last);
				end
			end
		end
	end

	initial begin
		watchdog_quiet = 0;
		while (watchdog_quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				watchdog_quiet = 0;
			else
				watchdog_quiet++;
		end
		$display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		in_ch.valid       = 1'b0;
		in_ch.op          = OP_LOAD;
		in_ch.entry_index = '0;
		in_ch.entry_time  = '0;
		in_ch.entry_value = '0;
		in_ch.query_time  = '0;
		calm              = 1'b0;
		point_count       = PC_RESET;
		failures          = 0;
		results_checked   = 0;
		loads_sent        = 0;
		queries_sent      = 0;
		clamps_low        = 0;
		clamps_high       = 0;
		settings_used     = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_two_points();
		test_unsorted_table();
		test_random_tables();

		drain_results();
		repeat (END_CYCLES) @(negedge clk);
		if (expected_results.size() != 0) begin
			failures += expected_results.size();
			$display("%0d expected results never arrived", expected_results.size());
		end
		$display("ran %0d breakpoint loads and %0d queries (%0d clamped low, %0d clamped high)",
			loads_sent, queries_sent, clamps_low, clamps_high);
		$display("over %0d point-count settings; %0d result beats compared, %0d failures",
			settings_used, results_checked, failures);
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
